// File: rtl/vlsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlsc_pkg: shared types and constants of the volume label sector checker
// Transaction structs, status codes, label text constants and the bytewise
// CRC-32 step.
// ----------------------------------------------------------------------------
package vlsc_pkg;

    // One sector byte and the sector number that the label has to record.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] expected_sector;
    } sector_item_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  word_index;
        logic [63:0] word_value;
        logic        last;
    } result_item_t;

    // Status codes.
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_MAGIC     = 3'd1;
    localparam logic [2:0] STATUS_TYPE      = 3'd2;
    localparam logic [2:0] STATUS_SECTOR    = 3'd3;
    localparam logic [2:0] STATUS_HDR_OFS   = 3'd4;
    localparam logic [2:0] STATUS_CRC       = 3'd5;
    localparam logic [2:0] STATUS_MISSING   = 3'd6;
    localparam logic [2:0] STATUS_META_SIZE = 3'd7;

    // Result word indexes.
    localparam logic [2:0] WORD_DATA_START = 3'd0;
    localparam logic [2:0] WORD_LAST       = 3'd6;
    localparam int         NUM_WORDS       = 7;

    // Label text, first byte in bits 7:0: "LABELONE" and "LVM2 001".
    localparam logic [63:0] MAGIC_TEXT = 64'h454E_4F4C_4542_414C;
    localparam logic [63:0] TYPE_TEXT  = 64'h3130_3020_324D_564C;

    // Sector layout.
    localparam logic [8:0]  POS_SECTOR_LO = 9'd8;
    localparam logic [8:0]  POS_CRC_LO    = 9'd16;
    localparam logic [8:0]  POS_HDR_LO    = 9'd20;
    localparam logic [8:0]  POS_HDR_HI    = 9'd23;
    localparam logic [8:0]  POS_TYPE_LO   = 9'd24;
    localparam logic [8:0]  POS_BODY      = 9'd32;
    localparam logic [8:0]  POS_LAST      = 9'd511;
    localparam logic [31:0] HDR_OFS_MIN   = 32'd32;
    localparam logic [31:0] HDR_OFS_MAX   = 32'd128;
    localparam logic [8:0]  UUID_BYTES    = 9'd32;
    localparam logic [8:0]  DESC_START    = 9'd40;
    localparam logic [63:0] META_LIMIT    = 64'd1048576;

    // Reflected CRC-32.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hF597_A6CF;

    // Advance the CRC by one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/volume_label_sector_checker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volume_label_sector_checker_top: physical-volume label checker
// Validates one 512-byte sector streamed a byte at a time and reports the
// data start, the metadata area and the volume uuid, or one error status.
// ----------------------------------------------------------------------------
// The block takes one sector byte per clock cycle; it counts the byte
// position itself, so sector transactions are simply sent in order, 512 to a
// sector. Every byte updates the field captures and the descriptor walk,
// bytes 20 to 511 also update the CRC, and the label is judged in the same
// cycle as byte 511 is taken. The verdict is copied into a result buffer,
// which then delivers either one error transaction or seven word transactions
// (data start, metadata offset, metadata size, uuid words 0 to 3), one per
// cycle unless result_stall holds them, with last set on the final one.
// Meanwhile the next sector streams in freely. The only input stall comes at
// byte 511 when the result buffer still holds the previous sector's results,
// so with the result side taking one transaction per cycle the input runs at
// one byte per cycle without a break. The lowest failing status code wins.
// ----------------------------------------------------------------------------
module volume_label_sector_checker_top (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   sector_valid,
    output logic                  sector_stall,
    input  wire vlsc_pkg::sector_item_t sector,
    output logic                  result_valid,
    input  wire                   result_stall,
    output vlsc_pkg::result_item_t result
);

    // One-hot phase of the descriptor list walk.
    typedef enum logic [2:0] {
        PHASE_DATA = 3'b001,
        PHASE_META = 3'b010,
        PHASE_DONE = 3'b100
    } phase_t;

    // Per-sector state.
    logic [8:0]  pos_reg;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [2:0]  first_err_reg, first_err_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [63:0] desc_low_reg, desc_low_next;
    logic [63:0] desc_high_reg, desc_high_next;
    phase_t      phase_reg, phase_next;
    logic [63:0] data_start_reg, data_start_next;
    logic [63:0] meta_ofs_reg, meta_ofs_next;
    logic [63:0] meta_size_reg, meta_size_next;
    logic [1:0]  seen_reg, seen_next;
    logic [63:0] uuid_reg [4];

    // Result buffer.
    logic        busy_reg;
    logic [2:0]  res_status_reg;
    logic [2:0]  res_index_reg;
    logic [63:0] res_words_reg [vlsc_pkg::NUM_WORDS];

    logic        in_take;
    logic        out_take;
    logic [7:0]  b;
    logic [2:0]  byte_code;
    logic        hdr_ok;
    logic [8:0]  off;
    logic        body_byte;
    logic        uuid_wr;
    logic        desc_wr;
    logic [8:0]  desc_off;
    logic [3:0]  lane;
    logic        pair_zero;
    logic [2:0]  final_status;
    logic        sector_end;

    assign in_take   = sector_valid && !sector_stall;
    assign out_take  = result_valid && !result_stall;
    assign b         = sector.data_byte;
    assign sector_end = (pos_reg == vlsc_pkg::POS_LAST);

    // Hold off the last byte of a sector while older results still wait.
    assign sector_stall = busy_reg && sector_end;

    // Per-byte checks: the ranges are disjoint, so at most one code a byte.
    always_comb
    begin
        byte_code       = vlsc_pkg::STATUS_OK;
        stored_crc_next = stored_crc_reg;
        hdr_next        = hdr_reg;
        if (pos_reg < vlsc_pkg::POS_SECTOR_LO)
        begin
            if (b != vlsc_pkg::MAGIC_TEXT[{pos_reg[2:0], 3'd0} +: 8])
            begin
                byte_code = vlsc_pkg::STATUS_MAGIC;
            end
        end
        else if (pos_reg < vlsc_pkg::POS_CRC_LO)
        begin
            if (b != sector.expected_sector[{pos_reg[2:0], 3'd0} +: 8])
            begin
                byte_code = vlsc_pkg::STATUS_SECTOR;
            end
        end
        else if (pos_reg < vlsc_pkg::POS_HDR_LO)
        begin
            stored_crc_next[{pos_reg[1:0], 3'd0} +: 8] = b;
        end
        else if (pos_reg < vlsc_pkg::POS_TYPE_LO)
        begin
            hdr_next[{pos_reg[1:0], 3'd0} +: 8] = b;
            if (pos_reg == vlsc_pkg::POS_HDR_HI &&
                (hdr_next < vlsc_pkg::HDR_OFS_MIN || hdr_next > vlsc_pkg::HDR_OFS_MAX))
            begin
                byte_code = vlsc_pkg::STATUS_HDR_OFS;
            end
        end
        else if (pos_reg < vlsc_pkg::POS_BODY)
        begin
            if (b != vlsc_pkg::TYPE_TEXT[{pos_reg[2:0], 3'd0} +: 8])
            begin
                byte_code = vlsc_pkg::STATUS_TYPE;
            end
        end

        if (byte_code != vlsc_pkg::STATUS_OK &&
            (first_err_reg == vlsc_pkg::STATUS_OK || byte_code < first_err_reg))
        begin
            first_err_next = byte_code;
        end
        else
        begin
            first_err_next = first_err_reg;
        end

        crc_next = (pos_reg >= vlsc_pkg::POS_HDR_LO) ? vlsc_pkg::crc_byte(crc_reg, b)
                                                     : crc_reg;
    end

    // Header body: uuid bytes, then descriptor pairs after the device size.
    assign hdr_ok    = (hdr_next >= vlsc_pkg::HDR_OFS_MIN) &&
                       (hdr_next <= vlsc_pkg::HDR_OFS_MAX);
    assign off       = pos_reg - hdr_next[8:0];
    assign body_byte = (pos_reg >= vlsc_pkg::POS_BODY) && hdr_ok &&
                       ({23'd0, pos_reg} >= hdr_next);
    assign uuid_wr   = body_byte && (off < vlsc_pkg::UUID_BYTES);
    assign desc_wr   = body_byte && (off >= vlsc_pkg::DESC_START);
    assign desc_off  = off - vlsc_pkg::DESC_START;
    assign lane      = desc_off[3:0];

    always_comb
    begin
        desc_low_next   = desc_low_reg;
        desc_high_next  = desc_high_reg;
        phase_next      = phase_reg;
        data_start_next = data_start_reg;
        meta_ofs_next   = meta_ofs_reg;
        meta_size_next  = meta_size_reg;
        seen_next       = seen_reg;
        if (desc_wr)
        begin
            if (!lane[3])
            begin
                desc_low_next[{lane[2:0], 3'd0} +: 8] = b;
            end
            else
            begin
                desc_high_next[{lane[2:0], 3'd0} +: 8] = b;
            end
        end
        pair_zero = (desc_low_next == 64'd0) && (desc_high_next == 64'd0);
        // A complete pair either ends the current list or is its entry.
        if (desc_wr && lane == 4'hF)
        begin
            unique case (phase_reg)
                PHASE_DATA:
                begin
                    if (pair_zero)
                    begin
                        phase_next = PHASE_META;
                    end
                    else if (!seen_reg[0])
                    begin
                        data_start_next = desc_low_next;
                        seen_next[0]    = 1'b1;
                    end
                end
                PHASE_META:
                begin
                    if (pair_zero)
                    begin
                        phase_next = PHASE_DONE;
                    end
                    else if (!seen_reg[1])
                    begin
                        meta_ofs_next  = desc_low_next;
                        meta_size_next = desc_high_next;
                        seen_next[1]   = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Verdict at the last byte, lowest code first.
    always_comb
    begin
        priority if (first_err_next != vlsc_pkg::STATUS_OK)
        begin
            final_status = first_err_next;
        end
        else if (crc_next != stored_crc_next)
        begin
            final_status = vlsc_pkg::STATUS_CRC;
        end
        else if (seen_next != 2'b11 || data_start_next == 64'd0 ||
                 meta_ofs_next == 64'd0 || meta_size_next == 64'd0)
        begin
            final_status = vlsc_pkg::STATUS_MISSING;
        end
        else if (meta_size_next > vlsc_pkg::META_LIMIT)
        begin
            final_status = vlsc_pkg::STATUS_META_SIZE;
        end
        else
        begin
            final_status = vlsc_pkg::STATUS_OK;
        end
    end

    // Sector state; every register returns to its start value after byte 511.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= vlsc_pkg::CRC_INIT;
            stored_crc_reg <= '0;
            first_err_reg  <= vlsc_pkg::STATUS_OK;
            hdr_reg        <= '0;
            desc_low_reg   <= '0;
            desc_high_reg  <= '0;
            phase_reg      <= PHASE_DATA;
            data_start_reg <= '0;
            meta_ofs_reg   <= '0;
            meta_size_reg  <= '0;
            seen_reg       <= '0;
        end
        else if (in_take)
        begin
            if (sector_end)
            begin
                pos_reg        <= '0;
                crc_reg        <= vlsc_pkg::CRC_INIT;
                stored_crc_reg <= '0;
                first_err_reg  <= vlsc_pkg::STATUS_OK;
                hdr_reg        <= '0;
                desc_low_reg   <= '0;
                desc_high_reg  <= '0;
                phase_reg      <= PHASE_DATA;
                data_start_reg <= '0;
                meta_ofs_reg   <= '0;
                meta_size_reg  <= '0;
                seen_reg       <= '0;
            end
            else
            begin
                pos_reg        <= pos_reg + 9'd1;
                crc_reg        <= crc_next;
                stored_crc_reg <= stored_crc_next;
                first_err_reg  <= first_err_next;
                hdr_reg        <= hdr_next;
                desc_low_reg   <= desc_low_next;
                desc_high_reg  <= desc_high_next;
                phase_reg      <= phase_next;
                data_start_reg <= data_start_next;
                meta_ofs_reg   <= meta_ofs_next;
                meta_size_reg  <= meta_size_next;
                seen_reg       <= seen_next;
            end
        end
    end

    // Uuid words keep their contents across sectors.
    always_ff @(posedge clk)
    begin
        if (in_take && uuid_wr)
        begin
            uuid_reg[off[4:3]][{off[2:0], 3'd0} +: 8] <= b;
        end
    end

    // Result buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_index_reg <= vlsc_pkg::WORD_DATA_START;
        end
        else if (in_take && sector_end)
        begin
            busy_reg      <= 1'b1;
            res_index_reg <= vlsc_pkg::WORD_DATA_START;
        end
        else if (out_take)
        begin
            if (result.last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                res_index_reg <= res_index_reg + 3'd1;
            end
        end
    end

    // Result buffer payload, loaded with the verdict of the finished sector.
    always_ff @(posedge clk)
    begin
        if (in_take && sector_end)
        begin
            res_status_reg   <= final_status;
            res_words_reg[0] <= data_start_next;
            res_words_reg[1] <= meta_ofs_next;
            res_words_reg[2] <= meta_size_next;
            res_words_reg[3] <= uuid_reg[0];
            res_words_reg[4] <= uuid_reg[1];
            res_words_reg[5] <= uuid_reg[2];
            res_words_reg[6] <= uuid_reg[3];
        end
    end

    // An error verdict is a single transaction with index and value zero.
    assign result_valid      = busy_reg;
    assign result.status     = res_status_reg;
    assign result.word_index = (res_status_reg == vlsc_pkg::STATUS_OK) ? res_index_reg
                                                                      : vlsc_pkg::WORD_DATA_START;
    assign result.word_value = (res_status_reg == vlsc_pkg::STATUS_OK) ?
                               res_words_reg[res_index_reg] : 64'd0;
    assign result.last       = (res_status_reg != vlsc_pkg::STATUS_OK) ||
                               (res_index_reg == vlsc_pkg::WORD_LAST);

endmodule
`default_nettype wire
